// ===== rtl/sactl_pkg.sv =====
// Package for the set-associative cache tag lookup unit.
// Holds the configuration record, register indexes, policy codes and counter helpers.
// No dependencies; every other file imports it.
package sactl_pkg;

    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int SET_OUT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_CACHE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd3;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [4:0] cache_size_log2;
        logic [3:0] block_size_log2;
        logic [1:0] ways_log2;
        logic       replace_policy;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cache_size_log2: 5'd16,
        block_size_log2: 4'd6,
        ways_log2:       2'd2,
        replace_policy:  POLICY_LRU
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ===== rtl/sactl_addr_if.sv =====
// Input channel of the tag lookup unit: one byte address per word.
// Depends on sactl_pkg for the address width.
interface sactl_addr_if
    import sactl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

// ===== rtl/sactl_res_if.sv =====
// Result channel of the tag lookup unit: hit, way, eviction, set and running counts.
// Depends on sactl_pkg for the field widths.
interface sactl_res_if
    import sactl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 evicted;
    logic [SET_OUT_W-1:0] set_index;
    logic [CNT_W-1:0]     access_count;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;

    modport source (output valid, output hit, output way_used, output evicted,
                    output set_index, output access_count, output hit_count,
                    output miss_count, input ready);
    modport sink   (input valid, input hit, input way_used, input evicted,
                    input set_index, input access_count, input hit_count,
                    input miss_count, output ready);
endinterface

// ===== rtl/sactl_addr_split.sv =====
// Address decoder: clamps the configured geometry and splits an address into set and tag.
// Also gives the highest way in use. Depends on sactl_pkg.
module sactl_addr_split
    import sactl_pkg::*;
#(
    parameter int MAX_SETS  = 1024,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  t_cfg                    i_cfg,
    input  logic [ADDR_W-1:0]       i_address,
    output logic [((($clog2(MAX_SETS+1)-1) > 0) ? ($clog2(MAX_SETS+1)-1) : 1)-1:0] o_set,
    output logic [((ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W)-1:0] o_tag,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_last_way
);

    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_AW = (IB_MAX > 0) ? IB_MAX : 1;
    localparam int TW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int WAW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));

    logic [ADDR_W-1:0] addr_m;
    logic [4:0]        n_log;
    logic [4:0]        m_log;
    logic [4:0]        rem_log;
    logic [4:0]        p_log;
    logic [4:0]        ib0;
    logic [4:0]        ib;
    logic [4:0]        tag_sh;
    logic [ADDR_W-1:0] set_full;
    logic [ADDR_W-1:0] tag_full;
    logic [4:0]        ways_n;
    logic [4:0]        last5;

    always_comb begin
        addr_m  = i_address & ADDR_MASK;
        n_log   = i_cfg.cache_size_log2;
        // A block larger than the cache shrinks to the cache.
        m_log   = ({1'b0, i_cfg.block_size_log2} > n_log) ? n_log : {1'b0, i_cfg.block_size_log2};
        rem_log = n_log - m_log;
        // Keep at least one set.
        p_log   = ({3'b000, i_cfg.ways_log2} > rem_log) ? rem_log : {3'b000, i_cfg.ways_log2};
        ib0     = rem_log - p_log;
        ib      = (ib0 > 5'(IB_MAX)) ? 5'(IB_MAX) : ib0;
        tag_sh  = m_log + ib;
        set_full = (addr_m >> m_log) & ((ADDR_W'(1) << ib) - ADDR_W'(1));
        tag_full = addr_m >> tag_sh;
        ways_n   = 5'd1 << p_log[1:0];
        last5    = (ways_n > 5'(MAX_WAYS)) ? 5'(MAX_WAYS - 1) : (ways_n - 5'd1);
    end

    assign o_set      = set_full[SET_AW-1:0];
    assign o_tag      = tag_full[TW-1:0];
    assign o_last_way = last5[WAW-1:0];

endmodule

// ===== rtl/set_assoc_cache_tag_lookup_unit.sv =====
// Top level of the set-associative cache tag lookup unit with FIFO or LRU replacement.
// Depends on sactl_pkg, sactl_addr_if, sactl_res_if and sactl_addr_split.
//
//  Channel   Dir  Handshake            Contents
//  i_addr    in   valid/ready          address
//  o_res     out  valid/ready          hit, way_used, evicted, set_index, counts
//  i_cfg_*   in   write enable only    register index and data, no read-back
//
// Each word is accepted and its set row read, then the ways in use are scanned one at a time
// through the single shared tag and stamp comparator, and the row is written back.
// The reset geometry uses four ways.
// After reset a clearing pass zeroes the valid bits, one set per cycle, over MAX_SETS rounded
// down to a power of two sets (1024 by default); no word is taken meanwhile.
// A stalled result holds in the output register; the next word may still be accepted.
module set_assoc_cache_tag_lookup_unit
    import sactl_pkg::*;
#(
    parameter int MAX_SETS  = 1024,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sactl_addr_if.sink            i_addr,
    sactl_res_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_AW = (IB_MAX > 0) ? IB_MAX : 1;
    localparam int ROWS   = 1 << IB_MAX;
    localparam int TW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int WAW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [SET_AW-1:0] LAST_ROW = SET_AW'(ROWS - 1);

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_SCAN, S_WRITE} t_state;

    t_cfg   r_cfg;
    t_state r_state;

    // Set memories, one row per set, all ways side by side.
    logic [MAX_WAYS-1:0]             r_mem_v [ROWS];
    logic [MAX_WAYS-1:0][TW-1:0]     r_mem_t [ROWS];
    logic [MAX_WAYS-1:0][CNT_W-1:0]  r_mem_s [ROWS];

    logic [MAX_WAYS-1:0]             r_vrow;
    logic [MAX_WAYS-1:0][TW-1:0]     r_trow;
    logic [MAX_WAYS-1:0][CNT_W-1:0]  r_srow;
    logic [MAX_WAYS-1:0]             n_vrow;
    logic [MAX_WAYS-1:0][TW-1:0]     n_trow;
    logic [MAX_WAYS-1:0][CNT_W-1:0]  n_srow;

    logic [SET_AW-1:0] s_set;
    logic [TW-1:0]     s_tag;
    logic [WAW-1:0]    s_last;

    logic [SET_AW-1:0] r_clr;
    logic [SET_AW-1:0] r_set;
    logic [TW-1:0]     r_tag;
    logic [WAW-1:0]    r_last;
    logic [WAW-1:0]    r_way;
    logic              r_hit;
    logic [WAW-1:0]    r_found;
    logic              r_empty;
    logic [WAW-1:0]    r_victim;
    logic [CNT_W-1:0]  r_best;
    logic [WAW-1:0]    r_minway;
    logic [CNT_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_miss;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [WAY_OUT_W-1:0] r_out_way;
    logic                 r_out_evicted;
    logic [SET_OUT_W-1:0] r_out_set;
    logic [CNT_W-1:0]     r_out_acc;
    logic [CNT_W-1:0]     r_out_hits;
    logic [CNT_W-1:0]     r_out_miss;

    logic              accept;
    logic              slot_free;
    logic              done;
    logic [WAW-1:0]    victim;
    logic [WAW-1:0]    way_sel;
    logic              mem_we_v;
    logic              mem_we_ts;
    logic [SET_AW-1:0] mem_wa;
    logic [31:0]       way_ext;
    logic [31:0]       set_ext;
    logic              scan_v;
    logic [TW-1:0]     scan_t;
    logic [CNT_W-1:0]  scan_s;

    sactl_addr_split #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_split (
        .i_cfg      (r_cfg),
        .i_address  (i_addr.address),
        .o_set      (s_set),
        .o_tag      (s_tag),
        .o_last_way (s_last)
    );

    assign accept    = i_addr.valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || o_res.ready;
    assign done      = (r_state == S_WRITE) && slot_free;

    assign scan_v = r_vrow[r_way];
    assign scan_t = r_trow[r_way];
    assign scan_s = r_srow[r_way];

    always_comb begin
        victim  = r_empty ? r_victim : r_minway;
        way_sel = r_hit ? r_found : victim;
        n_vrow  = r_vrow;
        n_trow  = r_trow;
        n_srow  = r_srow;
        if (r_state == S_CLR) begin
            n_vrow = '0;
        end else if (r_hit) begin
            if (r_cfg.replace_policy == POLICY_LRU) begin
                n_srow[r_found] = r_acc;
            end
        end else begin
            n_vrow[victim] = 1'b1;
            n_trow[victim] = r_tag;
            n_srow[victim] = r_acc;
        end
    end

    assign mem_we_v  = (r_state == S_CLR) || done;
    assign mem_we_ts = done;
    assign mem_wa    = (r_state == S_CLR) ? r_clr : r_set;
    assign way_ext   = 32'(way_sel);
    assign set_ext   = 32'(r_set);

    always_ff @(posedge i_clk) begin
        if (mem_we_v) begin
            r_mem_v[mem_wa] <= n_vrow;
        end
        if (mem_we_ts) begin
            r_mem_t[mem_wa] <= n_trow;
            r_mem_s[mem_wa] <= n_srow;
        end
        if (accept) begin
            r_vrow <= r_mem_v[s_set];
            r_trow <= r_mem_t[s_set];
            r_srow <= r_mem_s[s_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CACHE_SIZE: r_cfg.cache_size_log2 <= i_cfg_data[4:0];
                REG_BLOCK_SIZE: r_cfg.block_size_log2 <= i_cfg_data[3:0];
                REG_WAYS:       r_cfg.ways_log2       <= i_cfg_data[1:0];
                REG_POLICY:     r_cfg.replace_policy  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_hits      <= '0;
            r_miss      <= '0;
        end else begin
            // A word leaving in the same cycle as the next is loaded is handled below.
            if (r_out_valid && o_res.ready && !done) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + SET_AW'(1);
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_set   <= s_set;
                        r_tag   <= s_tag;
                        r_last  <= s_last;
                        r_acc   <= sat_inc(r_acc);
                        r_way   <= '0;
                        r_hit   <= 1'b0;
                        r_empty <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // The first valid match wins; the last invalid way seen is the fill
                    // candidate; the oldest stamp keeps the lowest way on a tie.
                    if (scan_v && !r_hit && (scan_t == r_tag)) begin
                        r_hit   <= 1'b1;
                        r_found <= r_way;
                    end
                    if (!scan_v) begin
                        r_empty  <= 1'b1;
                        r_victim <= r_way;
                    end
                    if ((r_way == '0) || (scan_s < r_best)) begin
                        r_best   <= scan_s;
                        r_minway <= r_way;
                    end
                    if (r_way == r_last) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_way <= r_way + WAW'(1);
                    end
                end
                S_WRITE: begin
                    if (slot_free) begin
                        if (r_hit) begin
                            r_hits <= sat_inc(r_hits);
                        end else begin
                            r_miss <= sat_inc(r_miss);
                        end
                        r_out_valid   <= 1'b1;
                        r_out_hit     <= r_hit;
                        r_out_way     <= way_ext[WAY_OUT_W-1:0];
                        r_out_evicted <= !r_hit && !r_empty;
                        r_out_set     <= set_ext[SET_OUT_W-1:0];
                        r_out_acc     <= r_acc;
                        r_out_hits    <= r_hit ? sat_inc(r_hits) : r_hits;
                        r_out_miss    <= r_hit ? r_miss : sat_inc(r_miss);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_addr.ready       = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.hit          = r_out_hit;
    assign o_res.way_used     = r_out_way;
    assign o_res.evicted      = r_out_evicted;
    assign o_res.set_index    = r_out_set;
    assign o_res.access_count = r_out_acc;
    assign o_res.hit_count    = r_out_hits;
    assign o_res.miss_count   = r_out_miss;

    // Between words, hits and misses account for every access until the count saturates.
    a_counts_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_acc != CNT_MAX)) |->
        (({1'b0, r_hits} + {1'b0, r_miss}) == {1'b0, r_acc}))
        else $error("hit and miss counts do not add up to the access count");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("result word appeared without a write-back step");

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_evicted && r_out_hit))
        else $error("eviction reported on a hit");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_way <= r_last))
        else $error("scan ran past the last way in use");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for set_assoc_cache_tag_lookup_unit: directed and random addresses
// under several cache geometries, each result word checked against a behavioural cache model.
// Depends on sactl_pkg, sactl_addr_if, sactl_res_if and the unit itself.
module tb
    import sactl_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_MAX_SETS    = 1024;
    localparam int TB_MAX_WAYS    = 8;
    localparam int SET_BITS_MAX   = $clog2(TB_MAX_SETS);
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 evicted;
        logic [SET_OUT_W-1:0] set_index;
        logic [CNT_W-1:0]     access_count;
        logic [CNT_W-1:0]     hit_count;
        logic [CNT_W-1:0]     miss_count;
    } lookup_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_CACHE_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sactl_addr_if addr_ch ();
    sactl_res_if  res_ch ();

    set_assoc_cache_tag_lookup_unit #(
        .MAX_SETS (TB_MAX_SETS),
        .MAX_WAYS (TB_MAX_WAYS),
        .ADDR_BITS(ADDR_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_addr    (addr_ch),
        .o_res     (res_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Model of the cache contents and counters.
    t_cfg             model_cfg = CFG_RESET;
    logic             cached_valid [TB_MAX_SETS*TB_MAX_WAYS];
    logic [ADDR_W-1:0] cached_tag  [TB_MAX_SETS*TB_MAX_WAYS];
    logic [CNT_W-1:0] cached_stamp [TB_MAX_SETS*TB_MAX_WAYS];
    logic [CNT_W-1:0] accesses = '0;
    logic [CNT_W-1:0] hits = '0;
    logic [CNT_W-1:0] misses = '0;

    logic [ADDR_W-1:0] address_backlog [$];
    lookup_t           pending_lookups [$];
    int                words_queued = 0;
    int                words_taken = 0;
    int                results_seen = 0;
    int                fail_count = 0;
    int                stall_cycles = 0;
    int                send_gap_max = 16;
    int                recv_gap_max = 16;
    int                send_wait = 0;
    int                recv_wait = 0;
    int                hold_left = 0;
    logic              hold_req = 1'b0;
    logic              addr_sent = 1'b0;
    logic              res_taken = 1'b0;

    initial begin
        addr_ch.valid   = 1'b0;
        addr_ch.address = '0;
        res_ch.ready    = 1'b0;
        for (int i = 0; i < TB_MAX_SETS*TB_MAX_WAYS; i++) begin
            cached_valid[i] = 1'b0;
        end
    end

    always #1 i_clk = ~i_clk;

    // Offset width, index width and way count under the current geometry, with all clamps.
    function automatic void split_geometry(output int unsigned off_bits,
                                           output int unsigned idx_bits,
                                           output int unsigned way_count);
        int unsigned total;
        int unsigned way_bits;
        total    = model_cfg.cache_size_log2;
        off_bits = (model_cfg.block_size_log2 > total) ? total : model_cfg.block_size_log2;
        way_bits = (model_cfg.ways_log2 > total - off_bits) ? total - off_bits
                                                            : model_cfg.ways_log2;
        idx_bits = total - off_bits - way_bits;
        if (idx_bits > SET_BITS_MAX) idx_bits = SET_BITS_MAX;
        way_count = 1 << way_bits;
        if (way_count > TB_MAX_WAYS) way_count = TB_MAX_WAYS;
    endfunction

    function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
        int unsigned       off_bits;
        int unsigned       idx_bits;
        int unsigned       way_count;
        int unsigned       set_no;
        int unsigned       base;
        int unsigned       victim;
        logic [ADDR_W-1:0] tag;
        logic [CNT_W-1:0]  oldest;
        logic              found_free;
        lookup_t           r;
        split_geometry(off_bits, idx_bits, way_count);
        set_no = (addr >> off_bits) & ((32'd1 << idx_bits) - 1);
        tag    = addr >> (off_bits + idx_bits);
        base   = set_no * TB_MAX_WAYS;
        if (accesses != CNT_MAX) accesses++;
        r          = '0;
        found_free = 1'b0;
        victim     = 0;
        for (int unsigned w = 0; w < way_count; w++) begin
            if (cached_valid[base + w]) begin
                if (!r.hit && cached_tag[base + w] == tag) begin
                    r.hit      = 1'b1;
                    r.way_used = WAY_OUT_W'(w);
                end
            end else begin
                // The last free way seen is the highest-numbered one.
                found_free = 1'b1;
                victim     = w;
            end
        end
        if (r.hit) begin
            if (hits != CNT_MAX) hits++;
            if (model_cfg.replace_policy == POLICY_LRU) cached_stamp[base + r.way_used] = accesses;
        end else begin
            if (misses != CNT_MAX) misses++;
            if (!found_free) begin
                victim = 0;
                oldest = cached_stamp[base];
                for (int unsigned w = 1; w < way_count; w++) begin
                    if (cached_stamp[base + w] < oldest) begin
                        oldest = cached_stamp[base + w];
                        victim = w;
                    end
                end
                r.evicted = 1'b1;
            end
            cached_valid[base + victim] = 1'b1;
            cached_tag[base + victim]   = tag;
            cached_stamp[base + victim] = accesses;
            r.way_used = WAY_OUT_W'(victim);
        end
        r.set_index    = SET_OUT_W'(set_no);
        r.access_count = accesses;
        r.hit_count    = hits;
        r.miss_count   = misses;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch: %s", what);
    endtask

    // Address sender: each word is followed by a random gap before the next is offered.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            addr_ch.valid <= 1'b0;
        end else if (!addr_ch.valid || addr_sent) begin
            if (send_wait > 0) begin
                send_wait--;
                addr_ch.valid <= 1'b0;
            end else if (address_backlog.size() != 0) begin
                addr_ch.valid   <= 1'b1;
                addr_ch.address <= address_backlog.pop_front();
                send_wait = $urandom_range(0, send_gap_max);
            end else begin
                addr_ch.valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result side, so that the unit backs up onto its input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (res_taken) recv_wait = $urandom_range(0, recv_gap_max);
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        lookup_t want;
        addr_sent = i_rst_n && addr_ch.valid && addr_ch.ready;
        res_taken = i_rst_n && res_ch.valid && res_ch.ready;
        if (res_taken) begin
            results_seen++;
            if (pending_lookups.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = pending_lookups.pop_front();
                if (res_ch.hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit %b, expected %b",
                                              results_seen, res_ch.hit, want.hit));
                if (res_ch.way_used !== want.way_used)
                    report_mismatch($sformatf("result %0d way_used %0d, expected %0d",
                                              results_seen, res_ch.way_used, want.way_used));
                if (res_ch.evicted !== want.evicted)
                    report_mismatch($sformatf("result %0d evicted %b, expected %b",
                                              results_seen, res_ch.evicted, want.evicted));
                if (res_ch.set_index !== want.set_index)
                    report_mismatch($sformatf("result %0d set_index %0d, expected %0d",
                                              results_seen, res_ch.set_index, want.set_index));
                if (res_ch.access_count !== want.access_count)
                    report_mismatch($sformatf("result %0d access_count %0d, expected %0d",
                                              results_seen, res_ch.access_count,
                                              want.access_count));
                if (res_ch.hit_count !== want.hit_count)
                    report_mismatch($sformatf("result %0d hit_count %0d, expected %0d",
                                              results_seen, res_ch.hit_count, want.hit_count));
                if (res_ch.miss_count !== want.miss_count)
                    report_mismatch($sformatf("result %0d miss_count %0d, expected %0d",
                                              results_seen, res_ch.miss_count,
                                              want.miss_count));
            end
        end
        if (addr_sent) begin
            pending_lookups.push_back(predict_lookup(addr_ch.address));
            words_taken++;
        end
        if (addr_sent || res_taken || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_address(input logic [ADDR_W-1:0] addr);
        address_backlog.push_back(addr);
        words_queued++;
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || pending_lookups.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CACHE_SIZE: model_cfg.cache_size_log2 = val[4:0];
            REG_BLOCK_SIZE: model_cfg.block_size_log2 = val[3:0];
            REG_WAYS:       model_cfg.ways_log2       = val[1:0];
            REG_POLICY:     model_cfg.replace_policy  = val[0];
            default: ;
        endcase
    endtask

    // One geometry: reprogram once idle, then a random mix that half the time revisits a small
    // set of lines (hits), crowds a few sets with new tags (evictions) and sprinkles in noise.
    task automatic run_phase(input t_cfg cfg, input int count, input int send_max,
                             input int recv_max, input bit squeeze);
        logic [ADDR_W-1:0] pool [16];
        int unsigned       off_bits;
        int unsigned       idx_bits;
        int unsigned       way_count;
        int unsigned       pick;
        int unsigned       k;
        wait_drained();
        write_reg(REG_CACHE_SIZE, CFG_DATA_W'(cfg.cache_size_log2));
        write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(cfg.block_size_log2));
        write_reg(REG_WAYS, CFG_DATA_W'(cfg.ways_log2));
        write_reg(REG_POLICY, CFG_DATA_W'(cfg.replace_policy));
        split_geometry(off_bits, idx_bits, way_count);
        send_gap_max = send_max;
        recv_gap_max = recv_max;
        if (squeeze) hold_req = 1'b1;
        foreach (pool[i]) pool[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            k    = $urandom_range(0, 15);
            if (pick < 5) begin
                queue_address(pool[k] ^ ($urandom & ((32'd1 << off_bits) - 1)));
            end else if (pick < 8) begin
                queue_address(pool[k] ^ (ADDR_W'($urandom_range(1, 7)) << (off_bits + idx_bits)));
            end else begin
                queue_address($urandom);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: 64-byte blocks, 256 sets of four ways, LRU.
        queue_address(32'h0000_0000);
        queue_address(32'hFFFF_FFFF);
        queue_address(32'h0000_003F);
        queue_address(32'hAAAA_AAAA);
        queue_address(32'h5555_5555);
        queue_address(32'h8000_0000);
        queue_address(32'h0000_0001);
        // Fill set 5 with four tags, touch the first, then force two evictions.
        for (int t = 1; t <= 4; t++) queue_address((t << 14) | (5 << 6));
        queue_address((1 << 14) | (5 << 6));
        queue_address((5 << 14) | (5 << 6));
        queue_address((2 << 14) | (5 << 6));
        queue_address((1 << 14) | (5 << 6) | 6'h2A);

        // Index wider than the set store: clamped, surplus bits join the tag. FIFO, one way.
        run_phase(t_cfg'{5'd24, 4'd0, 2'd0, POLICY_FIFO}, 60, 16, 16, 1'b0);
        // Block larger than the cache: a single line.
        run_phase(t_cfg'{5'd3, 4'd12, 2'd3, POLICY_LRU}, 30, 0, 16, 1'b0);
        // More ways asked for than the cache holds: clamped to four, one set.
        run_phase(t_cfg'{5'd3, 4'd1, 2'd3, POLICY_FIFO}, 60, 16, 0, 1'b0);
        // Eight ways at full rate, with the result side held off so the input backs up.
        run_phase(t_cfg'{5'd12, 4'd4, 2'd3, POLICY_LRU}, 100, 0, 0, 1'b1);
        run_phase(t_cfg'{5'd0, 4'd0, 2'd0, POLICY_LRU}, 30, 4, 4, 1'b0);
        run_phase(t_cfg'{5'd16, 4'd6, 2'd2, POLICY_FIFO}, 80, 16, 16, 1'b0);
        run_phase(t_cfg'{5'd20, 4'd5, 2'd3, POLICY_LRU}, 100, 8, 16, 1'b0);
        run_phase(t_cfg'{5'd24, 4'd12, 2'd1, POLICY_FIFO}, 60, 16, 4, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_lookups.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_lookups.size()));
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
